>>> rtl/tgrd_pkg.sv
// Package for the thermal-gated RGB duty unit: lane record and fixed constants.
// No dependencies; used by every other file of the block except tgrd_ifs.
package tgrd_pkg;

   localparam int NUM_WIDTH = 16;
   localparam int DIV_WIDTH = 8;
   localparam int CELL_COUNT = NUM_WIDTH;

   localparam logic [15:0] FULL_SCALE  = 16'hFFC0;
   localparam logic [7:0]  CODE_OFFSET = 8'd200;
   localparam logic [16:0] ROUND_HALF  = 17'd128;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] num;
      logic [DIV_WIDTH-1:0] rem;
      logic [NUM_WIDTH-1:0] quo;
      logic [DIV_WIDTH-1:0] div;
      logic [23:0]          frame_bits;
      logic                 frame_complete;
      logic                 divisor_zero;
   } lane_type;

endpackage

>>> rtl/tgrd_ifs.sv
// Channel interfaces of the thermal-gated RGB duty unit: request, response, CSR write.
// No dependencies.
interface tgrd_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] frame_bits;
   logic        frame_complete;
   logic [15:0] vref_before;
   logic [15:0] sensor_reading;
   logic [15:0] vref_after;

   modport source (output valid, frame_bits, frame_complete, vref_before, sensor_reading,
                   vref_after, input ready);
   modport sink (input valid, frame_bits, frame_complete, vref_before, sensor_reading,
                 vref_after, output ready);
endinterface

interface tgrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] green_duty;
   logic [15:0] red_duty;
   logic [15:0] blue_duty;
   logic [7:0]  temp_code;
   logic        divisor_zero;

   modport source (output valid, green_duty, red_duty, blue_duty, temp_code, divisor_zero,
                   input ready);
   modport sink (input valid, green_duty, red_duty, blue_duty, temp_code, divisor_zero,
                 output ready);
endinterface

interface tgrd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> rtl/tgrd_front.sv
// Input stage: averages the two reference readings and saturates the numerator.
// Depends on tgrd_pkg and tgrd_req_if.
module tgrd_front (
   input  logic              clock,
   input  logic              reset,
   tgrd_req_if.sink          req_bus,
   output logic              out_valid,
   input  logic              out_ready,
   output tgrd_pkg::lane_type out_lane
);

   logic               valid_ff;
   logic               valid_in;
   tgrd_pkg::lane_type lane_ff;
   tgrd_pkg::lane_type lane_in;
   logic [16:0]        sum;
   logic [7:0]         avg;
   logic               take;

   assign req_bus.ready = !valid_ff || out_ready;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      sum = {2'b00, req_bus.vref_before[15:1]} + {2'b00, req_bus.vref_after[15:1]}
            + tgrd_pkg::ROUND_HALF;
      avg = sum[15:8];
      lane_in.num = (req_bus.sensor_reading > tgrd_pkg::FULL_SCALE) ? '0
                    : tgrd_pkg::FULL_SCALE - req_bus.sensor_reading;
      lane_in.rem            = '0;
      lane_in.quo            = '0;
      lane_in.div            = avg;
      lane_in.frame_bits     = req_bus.frame_bits;
      lane_in.frame_complete = req_bus.frame_complete;
      lane_in.divisor_zero   = (avg == '0);
      valid_in = take || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

>>> rtl/tgrd_div_cell.sv
// One restoring-division cell: takes the next numerator bit, yields one quotient bit.
// Depends on tgrd_pkg.
module tgrd_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  tgrd_pkg::lane_type in_lane,
   output logic               out_valid,
   input  logic               out_ready,
   output tgrd_pkg::lane_type out_lane
);

   logic                            valid_ff;
   logic                            valid_in;
   tgrd_pkg::lane_type              lane_ff;
   tgrd_pkg::lane_type              lane_in;
   logic [tgrd_pkg::DIV_WIDTH:0]    trial;
   logic [tgrd_pkg::DIV_WIDTH:0]    diff;
   logic                            fits;
   logic                            take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      trial   = {in_lane.rem, in_lane.num[tgrd_pkg::NUM_WIDTH-1]};
      diff    = trial - {1'b0, in_lane.div};
      fits    = (trial >= {1'b0, in_lane.div});
      lane_in = in_lane;
      lane_in.num = {in_lane.num[tgrd_pkg::NUM_WIDTH-2:0], 1'b0};
      lane_in.rem = fits ? diff[tgrd_pkg::DIV_WIDTH-1:0] : trial[tgrd_pkg::DIV_WIDTH-1:0];
      lane_in.quo = {in_lane.quo[tgrd_pkg::NUM_WIDTH-2:0], fits};
      valid_in = take || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

>>> rtl/tgrd_back.sv
// Output stage: temperature code, colour gate and squaring into the response register.
// Depends on tgrd_pkg and tgrd_rsp_if.
module tgrd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         cool_limit,
   input  logic               in_valid,
   output logic               in_ready,
   input  tgrd_pkg::lane_type in_lane,
   tgrd_rsp_if.source         rsp_bus
);

   logic        valid_ff;
   logic        valid_in;
   logic [15:0] green_ff, red_ff, blue_ff;
   logic [7:0]  code_ff;
   logic        zero_ff;
   logic [7:0]  code;
   logic        show;
   logic [7:0]  red, green, blue;
   logic        take;

   assign in_ready = !valid_ff || rsp_bus.ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      code  = in_lane.quo[7:0] - tgrd_pkg::CODE_OFFSET;
      show  = !in_lane.divisor_zero && in_lane.frame_complete && (code >= cool_limit);
      red   = show ? in_lane.frame_bits[7:0]   : '0;
      green = show ? in_lane.frame_bits[15:8]  : '0;
      blue  = show ? in_lane.frame_bits[23:16] : '0;
      valid_in = take || (valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         red_ff   <= {8'h00, red} * {8'h00, red};
         green_ff <= {8'h00, green} * {8'h00, green};
         blue_ff  <= {8'h00, blue} * {8'h00, blue};
         code_ff  <= in_lane.divisor_zero ? '0 : code;
         zero_ff  <= in_lane.divisor_zero;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.red_duty     = red_ff;
   assign rsp_bus.green_duty   = green_ff;
   assign rsp_bus.blue_duty    = blue_ff;
   assign rsp_bus.temp_code    = code_ff;
   assign rsp_bus.divisor_zero = zero_ff;

endmodule

>>> rtl/thermal_gated_rgb_duty_unit.sv
// Thermal-gated RGB duty unit, top level: input stage, division cell chain, output stage.
// Depends on tgrd_pkg, tgrd_ifs, tgrd_front, tgrd_div_cell and tgrd_back.
//
// One frame is taken per cycle while the chain has room; each response passes one input
// stage, a chain of 16 division cells that each resolve one quotient bit, and one
// output register. Every stage holds its beat while the next is full, so the chain
// keeps taking beats as long as any stage ahead has room. cool_limit is written
// through the CSR channel, which is always ready.
module thermal_gated_rgb_duty_unit (
   input logic        clock,
   input logic        reset,
   tgrd_req_if.sink   req_bus,
   tgrd_rsp_if.source rsp_bus,
   tgrd_csr_if.sink   csr_bus
);

   logic [7:0]         cool_limit_ff;
   logic               chain_valid [tgrd_pkg::CELL_COUNT+1];
   logic               chain_ready [tgrd_pkg::CELL_COUNT+1];
   tgrd_pkg::lane_type chain_lane  [tgrd_pkg::CELL_COUNT+1];

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cool_limit_ff <= '0;
      end else if (csr_bus.valid) begin
         cool_limit_ff <= csr_bus.data;
      end
   end

   tgrd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_lane  (chain_lane[0])
   );

   for (genvar i = 0; i < tgrd_pkg::CELL_COUNT; i++) begin : g_cell
      tgrd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_lane   (chain_lane[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_lane  (chain_lane[i+1])
      );
   end

   tgrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cool_limit (cool_limit_ff),
      .in_valid   (chain_valid[tgrd_pkg::CELL_COUNT]),
      .in_ready   (chain_ready[tgrd_pkg::CELL_COUNT]),
      .in_lane    (chain_lane[tgrd_pkg::CELL_COUNT]),
      .rsp_bus    (rsp_bus)
   );

   assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.divisor_zero |->
         rsp_bus.temp_code == '0 && rsp_bus.red_duty == '0 &&
         rsp_bus.green_duty == '0 && rsp_bus.blue_duty == '0)
      else $error("zero divisor beat not dark");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.temp_code < cool_limit_ff |->
         rsp_bus.red_duty == '0 && rsp_bus.green_duty == '0 && rsp_bus.blue_duty == '0)
      else $error("colour shown below cool limit");

endmodule

>>> tb/thermal_gated_rgb_duty_unit_tb.sv
// Self-checking testbench for thermal_gated_rgb_duty_unit: directed and random frames
// against an in-bench duty predictor, with a paced sender, receiver stalls and a long hold-off.
// Depends on tgrd_pkg, tgrd_ifs and the unit's RTL.
module thermal_gated_rgb_duty_unit_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_TAIL     = 40;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_BEATS    = 90;
   localparam int PRESSURE_BEATS = 60;
   localparam int HOLD_CYCLES    = 120;

   typedef struct {
      logic [23:0] bits;
      logic        complete;
      logic [15:0] vref_before;
      logic [15:0] sensor;
      logic [15:0] vref_after;
   } frame_type;

   typedef struct {
      logic [15:0] green;
      logic [15:0] red;
      logic [15:0] blue;
      logic [7:0]  code;
      logic        zero;
   } duty_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_type;

   logic clock;
   logic reset;

   tgrd_req_if req_bus ();
   tgrd_rsp_if rsp_bus ();
   tgrd_csr_if csr_bus ();

   thermal_gated_rgb_duty_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   duty_type    pending_duties[$];
   duty_type    oldest_duty;
   logic [7:0]  cool_limit_shadow;
   int          mismatch_count;
   int          idle_cycles;
   bit          pace_enable;
   int          burst_left;
   int          hold_gen;
   int          hold_length;
   int          rx_seen_gen;
   int          rx_hold_left;
   int          rx_stall_left;
   int          rx_mode_left;
   int          rx_tick;
   rx_mode_type rx_mode;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic duty_type predict_duty(input frame_type f);
      logic [16:0] ref_sum;
      logic [7:0]  divisor;
      logic [15:0] numer;
      logic [15:0] quot;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      duty_type    d;
      ref_sum = {2'b00, f.vref_before[15:1]} + {2'b00, f.vref_after[15:1]}
                + tgrd_pkg::ROUND_HALF;
      divisor = ref_sum[15:8];
      d = '{default: '0};
      d.zero = (divisor == 8'd0);
      if (!d.zero) begin
         numer = (f.sensor > tgrd_pkg::FULL_SCALE) ? 16'd0 : tgrd_pkg::FULL_SCALE - f.sensor;
         quot = numer / divisor;
         d.code = quot[7:0] - tgrd_pkg::CODE_OFFSET;
         if (d.code >= cool_limit_shadow && f.complete) begin
            red   = {8'd0, f.bits[7:0]};
            green = {8'd0, f.bits[15:8]};
            blue  = {8'd0, f.bits[23:16]};
            d.red   = red * red;
            d.green = green * green;
            d.blue  = blue * blue;
         end
      end
      return d;
   endfunction

   function automatic frame_type make_frame(input logic [23:0] bits, input logic complete,
                                            input logic [15:0] vb, input logic [15:0] s,
                                            input logic [15:0] va);
      frame_type f;
      f.bits        = bits;
      f.complete    = complete;
      f.vref_before = vb;
      f.sensor      = s;
      f.vref_after  = va;
      return f;
   endfunction

   // mostly plausible ADC frames, the rest raw 16-bit noise
   function automatic frame_type random_frame();
      frame_type f;
      int        base;
      int        other;
      f.bits = 24'($urandom_range(0, 24'hFFFFFF));
      if ($urandom_range(0, 9) < 7) begin
         base  = $urandom_range(1, 1023);
         other = base + $urandom_range(0, 16) - 8;
         if (other < 0) other = 0;
         if (other > 1023) other = 1023;
         f.complete    = ($urandom_range(0, 15) != 0);
         f.vref_before = {base[9:0], 6'd0};
         f.vref_after  = {other[9:0], 6'd0};
         f.sensor      = {10'($urandom_range(0, 1023)), 6'd0};
      end else begin
         f.complete    = 1'($urandom_range(0, 1));
         f.vref_before = 16'($urandom_range(0, 16'hFFFF));
         f.vref_after  = 16'($urandom_range(0, 16'hFFFF));
         f.sensor      = 16'($urandom_range(0, 16'hFFFF));
      end
      return f;
   endfunction

   task automatic push_frame(input frame_type f);
      int gap;
      if (pace_enable && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_bus.valid          <= 1'b1;
      req_bus.frame_bits     <= f.bits;
      req_bus.frame_complete <= f.complete;
      req_bus.vref_before    <= f.vref_before;
      req_bus.sensor_reading <= f.sensor;
      req_bus.vref_after     <= f.vref_after;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_duties.push_back(predict_duty(f));
   endtask

   task automatic settle_pipeline();
      req_bus.valid <= 1'b0;
      while (pending_duties.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      cool_limit_shadow = value;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_field_extremes();
      settle_pipeline();
      write_limit(8'd0);
      pace_enable = 1'b0;
      push_frame(make_frame(24'h000000, 1'b1, 16'h0000, 16'h0000, 16'h0000));
      push_frame(make_frame(24'hFFFFFF, 1'b1, 16'hFFC0, 16'h8000, 16'hFFC0));
      push_frame(make_frame(24'hFFFFFF, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF));
      push_frame(make_frame(24'hFFFFFF, 1'b1, 16'hFE80, 16'h0000, 16'hFE80));
      push_frame(make_frame(24'hFFFFFF, 1'b1, 16'h0100, 16'h0000, 16'h0100));
      push_frame(make_frame(24'hFFFFFF, 1'b1, 16'h0100, 16'hFFC0, 16'h0100));
      push_frame(make_frame(24'hFFFFFF, 1'b1, 16'h8000, 16'hFFFF, 16'h8000));
      push_frame(make_frame(24'hFFFFFF, 1'b0, 16'h8000, 16'h4000, 16'h8000));
      push_frame(make_frame(24'h0000FF, 1'b1, 16'h8000, 16'h4000, 16'h8000));
      push_frame(make_frame(24'h00FF00, 1'b1, 16'h8000, 16'h4000, 16'h8000));
      push_frame(make_frame(24'hFF0000, 1'b1, 16'h8000, 16'h4000, 16'h8000));
      push_frame(make_frame(24'hA5C3E1, 1'b1, 16'h7FC0, 16'h3FC0, 16'h8040));
      push_frame(make_frame(24'h5A3C1E, 1'b1, 16'h00FF, 16'h003F, 16'h00FF));
      push_frame(make_frame(24'h000001, 1'b1, 16'h0080, 16'hFFFF, 16'h0080));
      settle_pipeline();
   endtask

   task automatic test_limit_edges();
      settle_pipeline();
      write_limit(8'd255);
      push_frame(make_frame(24'h123456, 1'b1, 16'h0100, 16'd65273, 16'h0100));
      push_frame(make_frame(24'h123456, 1'b1, 16'h0100, 16'd65274, 16'h0100));
      push_frame(make_frame(24'hFFFFFF, 1'b0, 16'h0100, 16'd65273, 16'h0100));
      settle_pipeline();
      write_limit(8'd56);
      push_frame(make_frame(24'hC0FFEE, 1'b1, 16'h8000, 16'hFFFF, 16'h8000));
      push_frame(make_frame(24'hC0FFEE, 1'b1, 16'h8000, 16'hFFC0, 16'h8000));
      settle_pipeline();
      write_limit(8'd57);
      push_frame(make_frame(24'hC0FFEE, 1'b1, 16'h8000, 16'hFFFF, 16'h8000));
      push_frame(make_frame(24'hC0FFEE, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF));
      settle_pipeline();
   endtask

   task automatic test_random_frames();
      logic [7:0] limit;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_pipeline();
         case (phase)
            0: limit = 8'd0;
            1: limit = 8'd255;
            default: limit = 8'($urandom_range(0, 255));
         endcase
         write_limit(limit);
         pace_enable = ($urandom_range(0, 3) != 0);
         burst_left = 0;
         repeat (PHASE_BEATS) push_frame(random_frame());
      end
      settle_pipeline();
   endtask

   task automatic test_backpressure_fill();
      settle_pipeline();
      write_limit(8'($urandom_range(0, 120)));
      pace_enable = 1'b0;
      hold_length = HOLD_CYCLES;
      hold_gen++;
      repeat (PRESSURE_BEATS) push_frame(random_frame());
      settle_pipeline();
   endtask

   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_duties.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual temp_code %0d",
                     $time, rsp_bus.temp_code);
            mismatch_count++;
         end else begin
            oldest_duty = pending_duties.pop_front();
            report_field("green_duty", oldest_duty.green, rsp_bus.green_duty);
            report_field("red_duty", oldest_duty.red, rsp_bus.red_duty);
            report_field("blue_duty", oldest_duty.blue, rsp_bus.blue_duty);
            report_field("temp_code", {8'd0, oldest_duty.code}, {8'd0, rsp_bus.temp_code});
            report_field("divisor_zero", {15'd0, oldest_duty.zero},
                         {15'd0, rsp_bus.divisor_zero});
         end
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      rx_seen_gen   = 0;
      rx_hold_left  = 0;
      rx_stall_left = 0;
      rx_mode_left  = 0;
      rx_tick       = 0;
      rx_mode       = RX_OPEN;
      forever begin
         @(posedge clock);
         rx_tick++;
         if (rx_mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 150);
         end
         rx_mode_left--;
         if (hold_gen != rx_seen_gen) begin
            rx_seen_gen = hold_gen;
            rx_hold_left = hold_length;
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN: rsp_bus.ready <= 1'b1;
               RX_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_bus.ready <= (rx_tick % 3 == 0);
               default: begin
                  if (rx_stall_left > 0) begin
                     rx_stall_left--;
                     rsp_bus.ready <= 1'b0;
                  end else if ($urandom_range(0, 15) == 0) begin
                     rx_stall_left = $urandom_range(1, 25);
                     rsp_bus.ready <= 1'b0;
                  end else begin
                     rsp_bus.ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      mismatch_count         = 0;
      idle_cycles            = 0;
      pace_enable            = 1'b0;
      burst_left             = 0;
      hold_gen               = 0;
      hold_length            = 0;
      cool_limit_shadow      = 8'd0;
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.frame_bits     <= '0;
      req_bus.frame_complete <= 1'b0;
      req_bus.vref_before    <= '0;
      req_bus.sensor_reading <= '0;
      req_bus.vref_after     <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.data           <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_limit_edges();
      test_backpressure_fill();
      test_random_frames();
      test_backpressure_fill();
      settle_pipeline();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0 && pending_duties.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/tgrd_pkg.sv
rtl/tgrd_ifs.sv
rtl/tgrd_front.sv
rtl/tgrd_div_cell.sv
rtl/tgrd_back.sv
rtl/thermal_gated_rgb_duty_unit.sv
tb/thermal_gated_rgb_duty_unit_tb.sv
